### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define ASSERT_NEXT_NORST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset check failed");

`endif

### hw/rtl/ejq_pkg.sv
// Shared widths, constants and the side payload type of the Jacobian pipeline.
`timescale 1ns / 1ps
package ejq_pkg;

    localparam int QW         = 17;   // quaternion component after sign fold
    localparam int NUM_W      = 53;   // signed numerator width
    localparam int DEN_W      = 54;   // divisor width
    localparam int E_W        = 58;   // radicand width
    localparam int ROOT_W     = 29;
    localparam int TOL_W      = 29;
    localparam int OUT_W      = 32;
    localparam int N_ENT      = 12;
    localparam int N_NUM      = 8;
    localparam int ISQ_STAGES = 29;
    localparam int QBITS      = 31;
    localparam int SHIFT_LONG = 30;
    localparam int SHIFT_SHORT = 18;
    localparam int NMAG_W     = NUM_W + SHIFT_LONG;
    localparam int CMP_W      = DEN_W + QBITS;

    localparam logic [TOL_W-1:0] TOL_RESET = 29'd2684;
    localparam logic [32:0] ONE_Q28  = 33'h010000000;
    localparam logic [32:0] HALF_Q28 = 33'h008000000;

    typedef struct packed {
        logic [N_NUM-1:0][NUM_W-1:0] nums;
        logic [DEN_W-1:0]            d_roll;
        logic [DEN_W-1:0]            d_yaw;
        logic [31:0]                 g;
        logic signed [QW-1:0]        x;
        logic signed [QW-1:0]        y;
        logic signed [QW-1:0]        z;
        logic signed [QW-1:0]        w;
        logic                        lock;
        logic                        det_neg;
    } side_t;

endpackage

### hw/rtl/ejq_front.sv
// Front stages: sign fold, products, determinant, gimbal test, numerators and divisors.
`timescale 1ns / 1ps
module ejq_front import ejq_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [15:0]      quat_x,
    input  logic signed [15:0]      quat_y,
    input  logic signed [15:0]      quat_z,
    input  logic signed [15:0]      quat_w,
    input  logic [TOL_W-1:0]        tol,
    output logic                    out_valid,
    output logic [E_W-1:0]          out_e,
    output side_t                   out_side
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // Stage 1
    logic signed [QW-1:0] x1_reg, y1_reg, z1_reg, w1_reg;
    logic signed [QW-1:0] x1_next, y1_next, z1_next, w1_next;
    // Stage 2
    logic signed [33:0] wy2_reg, xz2_reg, xx2_reg, yy2_reg, zz2_reg;
    logic signed [33:0] wx2_reg, yz2_reg, wz2_reg, xy2_reg, ww2_reg;
    logic signed [QW-1:0] x2_reg, y2_reg, z2_reg, w2_reg;
    // Stage 3
    logic signed [34:0] det3_reg, t1_3_reg, t2_3_reg, t5_3_reg, t6_3_reg;
    logic signed [34:0] det3_next, t1_3_next, t2_3_next, t5_3_next, t6_3_next, g3_full;
    logic [31:0] g3_reg;
    logic signed [QW-1:0] x3_reg, y3_reg, z3_reg, w3_reg;
    // Stage 4
    logic [32:0] ad4_reg, ad4_next;
    logic det_neg4_reg, big4_reg;
    logic [26:0] at1_4_reg, at2_4_reg, at5_4_reg, at6_4_reg;
    logic [26:0] at1_4_next, at2_4_next, at5_4_next, at6_4_next;
    logic signed [34:0] abs1, abs2, abs5, abs6, absd;
    logic signed [51:0] p_wt1_reg, p_xt2_reg, p_zt1_reg, p_yt2_reg, p_yt1_reg, p_xt1_reg;
    logic signed [51:0] p_yt5_reg, p_xt5_reg, p_yt6_reg, p_wt5_reg, p_zt6_reg, p_zt5_reg;
    logic [31:0] g4_reg;
    logic signed [QW-1:0] x4_reg, y4_reg, z4_reg, w4_reg;
    // Stage 5
    logic lock5_reg, lock5_next, det_neg5_reg;
    logic [32:0] dist5, a1_full, a2_full;
    logic [28:0] a1_5_reg, a1_5_next;
    logic [29:0] a2_5_reg;
    logic [53:0] sq1_5_reg, sq2_5_reg, sq5_5_reg, sq6_5_reg;
    logic [N_NUM-1:0][NUM_W-1:0] nums5_reg, nums5_next;
    logic signed [NUM_W-1:0] n_rx, n_ry, n_rz, n_rw, n_yx, n_yy, n_yz, n_yw;
    logic [31:0] g5_reg;
    logic signed [QW-1:0] x5_reg, y5_reg, z5_reg, w5_reg;
    // Stage 6
    logic [58:0] e_full;
    logic [E_W-1:0] e6_reg;
    side_t side6_reg, side6_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // A negative w flips the whole quaternion; 17 bits keep -32768 from wrapping.
    always_comb begin
        x1_next = QW'(quat_x);
        y1_next = QW'(quat_y);
        z1_next = QW'(quat_z);
        w1_next = QW'(quat_w);
        if (quat_w[15]) begin
            x1_next = -x1_next;
            y1_next = -y1_next;
            z1_next = -z1_next;
            w1_next = -w1_next;
        end
    end

    always_comb begin
        det3_next = 35'(wy2_reg) - 35'(xz2_reg);
        t1_3_next = $signed({2'b00, ONE_Q28}) - ((35'(xx2_reg) + 35'(yy2_reg)) <<< 1);
        t2_3_next = (35'(wx2_reg) + 35'(yz2_reg)) <<< 1;
        t5_3_next = $signed({2'b00, ONE_Q28}) - ((35'(yy2_reg) + 35'(zz2_reg)) <<< 1);
        t6_3_next = (35'(wz2_reg) + 35'(xy2_reg)) <<< 1;
        g3_full   = 35'(ww2_reg) + 35'(xx2_reg);
    end

    always_comb begin
        absd = det3_reg[34] ? -det3_reg : det3_reg;
        abs1 = t1_3_reg[34] ? -t1_3_reg : t1_3_reg;
        abs2 = t2_3_reg[34] ? -t2_3_reg : t2_3_reg;
        abs5 = t5_3_reg[34] ? -t5_3_reg : t5_3_reg;
        abs6 = t6_3_reg[34] ? -t6_3_reg : t6_3_reg;
        ad4_next   = absd[32:0];
        at1_4_next = abs1[32:6];
        at2_4_next = abs2[32:6];
        at5_4_next = abs5[32:6];
        at6_4_next = abs6[32:6];
    end

    always_comb begin
        dist5      = (ad4_reg > HALF_Q28) ? ad4_reg - HALF_Q28 : HALF_Q28 - ad4_reg;
        lock5_next = dist5 <= {4'b0000, tol};
        a1_full    = ONE_Q28 - (ad4_reg << 1);
        a2_full    = ONE_Q28 + (ad4_reg << 1);
        // Past one half the root is not real; a zero radicand gives a zero divisor.
        a1_5_next  = big4_reg ? '0 : a1_full[28:0];
        n_rx = (NUM_W'(p_wt1_reg) <<< 1) + (NUM_W'(p_xt2_reg) <<< 2);
        n_ry = (NUM_W'(p_zt1_reg) <<< 1) + (NUM_W'(p_yt2_reg) <<< 2);
        n_rz = NUM_W'(p_yt1_reg) <<< 1;
        n_rw = NUM_W'(p_xt1_reg) <<< 1;
        n_yx = NUM_W'(p_yt5_reg) <<< 1;
        n_yy = (NUM_W'(p_xt5_reg) <<< 1) + (NUM_W'(p_yt6_reg) <<< 2);
        n_yz = (NUM_W'(p_wt5_reg) <<< 1) + (NUM_W'(p_zt6_reg) <<< 2);
        n_yw = NUM_W'(p_zt5_reg) <<< 1;
        nums5_next = {n_yw, n_yz, n_yy, n_yx, n_rw, n_rz, n_ry, n_rx};
    end

    always_comb begin
        e_full = {30'b0, a1_5_reg} * {29'b0, a2_5_reg};
        side6_next.nums    = nums5_reg;
        side6_next.d_roll  = sq1_5_reg + sq2_5_reg;
        side6_next.d_yaw   = sq5_5_reg + sq6_5_reg;
        side6_next.g       = g5_reg;
        side6_next.x       = x5_reg;
        side6_next.y       = y5_reg;
        side6_next.z       = z5_reg;
        side6_next.w       = w5_reg;
        side6_next.lock    = lock5_reg;
        side6_next.det_neg = det_neg5_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg <= x1_next;
            y1_reg <= y1_next;
            z1_reg <= z1_next;
            w1_reg <= w1_next;

            wy2_reg <= w1_reg * y1_reg;
            xz2_reg <= x1_reg * z1_reg;
            xx2_reg <= x1_reg * x1_reg;
            yy2_reg <= y1_reg * y1_reg;
            zz2_reg <= z1_reg * z1_reg;
            wx2_reg <= w1_reg * x1_reg;
            yz2_reg <= y1_reg * z1_reg;
            wz2_reg <= w1_reg * z1_reg;
            xy2_reg <= x1_reg * y1_reg;
            ww2_reg <= w1_reg * w1_reg;
            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
            z2_reg  <= z1_reg;
            w2_reg  <= w1_reg;

            det3_reg <= det3_next;
            t1_3_reg <= t1_3_next;
            t2_3_reg <= t2_3_next;
            t5_3_reg <= t5_3_next;
            t6_3_reg <= t6_3_next;
            g3_reg   <= g3_full[31:0];
            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            z3_reg   <= z2_reg;
            w3_reg   <= w2_reg;

            ad4_reg      <= ad4_next;
            det_neg4_reg <= det3_reg[34];
            big4_reg     <= ad4_next >= HALF_Q28;
            at1_4_reg    <= at1_4_next;
            at2_4_reg    <= at2_4_next;
            at5_4_reg    <= at5_4_next;
            at6_4_reg    <= at6_4_next;
            p_wt1_reg    <= w3_reg * t1_3_reg;
            p_xt2_reg    <= x3_reg * t2_3_reg;
            p_zt1_reg    <= z3_reg * t1_3_reg;
            p_yt2_reg    <= y3_reg * t2_3_reg;
            p_yt1_reg    <= y3_reg * t1_3_reg;
            p_xt1_reg    <= x3_reg * t1_3_reg;
            p_yt5_reg    <= y3_reg * t5_3_reg;
            p_xt5_reg    <= x3_reg * t5_3_reg;
            p_yt6_reg    <= y3_reg * t6_3_reg;
            p_wt5_reg    <= w3_reg * t5_3_reg;
            p_zt6_reg    <= z3_reg * t6_3_reg;
            p_zt5_reg    <= z3_reg * t5_3_reg;
            g4_reg       <= g3_reg;
            x4_reg       <= x3_reg;
            y4_reg       <= y3_reg;
            z4_reg       <= z3_reg;
            w4_reg       <= w3_reg;

            lock5_reg    <= lock5_next;
            det_neg5_reg <= det_neg4_reg;
            a1_5_reg     <= a1_5_next;
            a2_5_reg     <= a2_full[29:0];
            sq1_5_reg    <= at1_4_reg * at1_4_reg;
            sq2_5_reg    <= at2_4_reg * at2_4_reg;
            sq5_5_reg    <= at5_4_reg * at5_4_reg;
            sq6_5_reg    <= at6_4_reg * at6_4_reg;
            nums5_reg    <= nums5_next;
            g5_reg       <= g4_reg;
            x5_reg       <= x4_reg;
            y5_reg       <= y4_reg;
            z5_reg       <= z4_reg;
            w5_reg       <= w4_reg;

            e6_reg    <= e_full[E_W-1:0];
            side6_reg <= side6_next;
        end
    end

    assign out_valid = v6_reg;
    assign out_e     = e6_reg;
    assign out_side  = side6_reg;

endmodule

### hw/rtl/ejq_isqrt.sv
// Pipelined integer square root, one result bit per stage, with side payload.
`timescale 1ns / 1ps
module ejq_isqrt import ejq_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [E_W-1:0]    in_e,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output side_t             out_side
);

    logic [E_W-1:0] v_reg    [ISQ_STAGES];
    logic [E_W-1:0] v_next   [ISQ_STAGES];
    logic [E_W-1:0] res_reg  [ISQ_STAGES];
    logic [E_W-1:0] res_next [ISQ_STAGES];
    side_t          side_reg [ISQ_STAGES];
    logic           vld_reg  [ISQ_STAGES];

    always_comb begin
        logic [E_W-1:0] v_in;
        logic [E_W-1:0] res_in;
        logic [E_W-1:0] bitv;
        logic [E_W-1:0] trial;
        for (int s = 0; s < ISQ_STAGES; s++) begin
            v_in   = (s == 0) ? in_e : v_reg[(s == 0) ? 0 : s - 1];
            res_in = (s == 0) ? '0 : res_reg[(s == 0) ? 0 : s - 1];
            bitv   = {{(E_W-1){1'b0}}, 1'b1} << (2 * (ISQ_STAGES - 1 - s));
            trial  = res_in + bitv;
            if (v_in >= trial) begin
                v_next[s]   = v_in - trial;
                res_next[s] = (res_in >> 1) + bitv;
            end else begin
                v_next[s]   = v_in;
                res_next[s] = res_in >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < ISQ_STAGES; s++) begin
                vld_reg[s] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < ISQ_STAGES; s++) begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int s = 1; s < ISQ_STAGES; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
            for (int s = 0; s < ISQ_STAGES; s++) begin
                v_reg[s]   <= v_next[s];
                res_reg[s] <= res_next[s];
            end
        end
    end

    assign out_valid = vld_reg[ISQ_STAGES-1];
    assign out_root  = res_reg[ISQ_STAGES-1][ROOT_W-1:0];
    assign out_side  = side_reg[ISQ_STAGES-1];

endmodule

### hw/rtl/ejq_div.sv
// Pipelined saturating fixed-point divider, one quotient bit per stage.
`timescale 1ns / 1ps
module ejq_div import ejq_pkg::*; (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [NUM_W-1:0] num,
    input  logic                    long_shift,
    input  logic [DEN_W-1:0]        den,
    output logic [OUT_W-1:0]        result
);

    logic [NUM_W-1:0]  mag;
    logic [NMAG_W-1:0] n_next;
    logic              a_neg_reg;
    logic [NMAG_W-1:0] a_n_reg;
    logic [DEN_W-1:0]  a_den_reg;

    logic              b_neg_reg, b_zero_reg, b_sat_reg;
    logic [NMAG_W-1:0] b_r_reg;
    logic [DEN_W-1:0]  b_den_reg;

    logic [NMAG_W-1:0] r_reg   [QBITS];
    logic [NMAG_W-1:0] r_next  [QBITS];
    logic [QBITS-1:0]  q_reg   [QBITS];
    logic [QBITS-1:0]  q_next  [QBITS];
    logic [DEN_W-1:0]  d_reg   [QBITS];
    logic              neg_reg [QBITS];
    logic              zero_reg[QBITS];
    logic              sat_reg [QBITS];

    always_comb begin
        mag    = num[NUM_W-1] ? -num : num;
        n_next = long_shift ? {mag, {SHIFT_LONG{1'b0}}}
                            : {{(SHIFT_LONG-SHIFT_SHORT){1'b0}}, mag, {SHIFT_SHORT{1'b0}}};
    end

    // Each stage tries the divisor at one bit position; the saturation test
    // beforehand guarantees the quotient fits below two to the 31.
    always_comb begin
        logic [NMAG_W-1:0] r_in;
        logic [QBITS-1:0]  q_in;
        logic [DEN_W-1:0]  d_in;
        logic [CMP_W-1:0]  dsh;
        for (int j = 0; j < QBITS; j++) begin
            r_in = (j == 0) ? b_r_reg : r_reg[(j == 0) ? 0 : j - 1];
            q_in = (j == 0) ? '0 : q_reg[(j == 0) ? 0 : j - 1];
            d_in = (j == 0) ? b_den_reg : d_reg[(j == 0) ? 0 : j - 1];
            dsh  = {{QBITS{1'b0}}, d_in} << (QBITS - 1 - j);
            r_next[j] = r_in;
            q_next[j] = q_in;
            if ({{(CMP_W-NMAG_W){1'b0}}, r_in} >= dsh) begin
                r_next[j] = r_in - dsh[NMAG_W-1:0];
                q_next[j][QBITS-1-j] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_neg_reg  <= num[NUM_W-1];
            a_n_reg    <= n_next;
            a_den_reg  <= den;

            b_neg_reg  <= a_neg_reg;
            b_zero_reg <= a_n_reg == '0;
            b_sat_reg  <= {{(CMP_W-NMAG_W){1'b0}}, a_n_reg} >= {a_den_reg, {QBITS{1'b0}}};
            b_r_reg    <= a_n_reg;
            b_den_reg  <= a_den_reg;

            neg_reg[0]  <= b_neg_reg;
            zero_reg[0] <= b_zero_reg;
            sat_reg[0]  <= b_sat_reg;
            for (int j = 1; j < QBITS; j++) begin
                neg_reg[j]  <= neg_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
                sat_reg[j]  <= sat_reg[j-1];
                d_reg[j]    <= d_reg[j-1];
            end
            d_reg[0] <= b_den_reg;
            for (int j = 0; j < QBITS; j++) begin
                r_reg[j] <= r_next[j];
                q_reg[j] <= q_next[j];
            end
        end
    end

    always_comb begin
        if (zero_reg[QBITS-1]) begin
            result = '0;
        end else if (sat_reg[QBITS-1]) begin
            result = neg_reg[QBITS-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end else if (neg_reg[QBITS-1]) begin
            result = -{1'b0, q_reg[QBITS-1]};
        end else begin
            result = {1'b0, q_reg[QBITS-1]};
        end
    end

endmodule

### hw/rtl/euler_from_quaternion_jacobian.sv
// Top level: Jacobian of roll, pitch and yaw with respect to a unit quaternion.
// Usage:
//   An item (s_quat_x/y/z/w, signed Q1.14) is taken on s_valid and s_ready.
//   One result item of twelve signed Q15.16 entries leaves on m_valid and
//   m_ready, in the order the items came in.
//   From acceptance to m_valid an item passes six front stages,
//   29 square-root stages (one root bit each), 33 divider stages (operand
//   set-up, saturation test, then one quotient bit each) and the output register.
//   Throughput is one item per cycle while m_ready is high.
//   When m_ready is low the output register holds its item and the pipeline
//   keeps moving until one more item lands in a skid register; only then does
//   s_ready fall, and the whole pipeline holds until the skid drains.
//   gimbal_tolerance is written through cfg_wr_en/cfg_wr_data; the user must
//   write it only while idle, as the block does not enforce this. A synchronous
//   low aresetn empties the pipeline and sets the tolerance to 2684.
`timescale 1ns / 1ps
module euler_from_quaternion_jacobian import ejq_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [TOL_W-1:0]        cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [15:0]      s_quat_x,
    input  logic signed [15:0]      s_quat_y,
    input  logic signed [15:0]      s_quat_z,
    input  logic signed [15:0]      s_quat_w,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_roll_by_x,
    output logic signed [OUT_W-1:0] m_roll_by_y,
    output logic signed [OUT_W-1:0] m_roll_by_z,
    output logic signed [OUT_W-1:0] m_roll_by_w,
    output logic signed [OUT_W-1:0] m_pitch_by_x,
    output logic signed [OUT_W-1:0] m_pitch_by_y,
    output logic signed [OUT_W-1:0] m_pitch_by_z,
    output logic signed [OUT_W-1:0] m_pitch_by_w,
    output logic signed [OUT_W-1:0] m_yaw_by_x,
    output logic signed [OUT_W-1:0] m_yaw_by_y,
    output logic signed [OUT_W-1:0] m_yaw_by_z,
    output logic signed [OUT_W-1:0] m_yaw_by_w
);

    localparam int ROLL  = 0;
    localparam int PITCH = 4;
    localparam int YAW   = 8;
    localparam int BY_X  = 0;
    localparam int BY_Y  = 1;
    localparam int BY_Z  = 2;
    localparam int BY_W  = 3;
    localparam int DIV_STAGES = QBITS + 2;

    logic [TOL_W-1:0] gimbal_tolerance_reg;
    logic             adv;

    logic             f_valid;
    logic [E_W-1:0]   f_e;
    side_t            f_side;
    logic             q_valid;
    logic [ROOT_W-1:0] q_root;
    side_t            q_side;

    logic signed [NUM_W-1:0] num_sel  [N_ENT];
    logic [DEN_W-1:0]        den_sel  [N_ENT];
    logic                    long_sel [N_ENT];
    logic [OUT_W-1:0]        div_res  [N_ENT];
    logic                    div_vld_reg [DIV_STAGES];

    logic [OUT_W-1:0] out_data_reg  [N_ENT];
    logic [OUT_W-1:0] skid_data_reg [N_ENT];
    logic             m_valid_reg, skid_valid_reg;
    logic             last_vld, load_out, load_skid, drain_skid;

    logic signed [NUM_W-1:0] two_w, two_x, two_y, two_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gimbal_tolerance_reg <= TOL_RESET;
        end else if (cfg_wr_en) begin
            gimbal_tolerance_reg <= cfg_wr_data;
        end
    end

    assign adv     = !skid_valid_reg;
    assign s_ready = adv;

    ejq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (s_valid),
        .quat_x    (s_quat_x),
        .quat_y    (s_quat_y),
        .quat_z    (s_quat_z),
        .quat_w    (s_quat_w),
        .tol       (gimbal_tolerance_reg),
        .out_valid (f_valid),
        .out_e     (f_e),
        .out_side  (f_side)
    );

    ejq_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (f_valid),
        .in_e      (f_e),
        .in_side   (f_side),
        .out_valid (q_valid),
        .out_root  (q_root),
        .out_side  (q_side)
    );

    // Operand selection: in gimbal lock only the two yaw entries divide by w^2+x^2.
    always_comb begin
        two_w = NUM_W'(q_side.w) <<< 1;
        two_x = NUM_W'(q_side.x) <<< 1;
        two_y = NUM_W'(q_side.y) <<< 1;
        two_z = NUM_W'(q_side.z) <<< 1;
        for (int k = 0; k < N_ENT; k++) begin
            num_sel[k]  = '0;
            den_sel[k]  = '0;
            long_sel[k] = 1'b0;
        end
        if (q_side.lock) begin
            num_sel[YAW+BY_X]  = q_side.det_neg ? two_w : -two_w;
            num_sel[YAW+BY_W]  = q_side.det_neg ? -two_x : two_x;
            den_sel[YAW+BY_X]  = {{(DEN_W-32){1'b0}}, q_side.g};
            den_sel[YAW+BY_W]  = {{(DEN_W-32){1'b0}}, q_side.g};
            long_sel[YAW+BY_X] = 1'b1;
            long_sel[YAW+BY_W] = 1'b1;
        end else begin
            for (int k = 0; k < 4; k++) begin
                num_sel[ROLL+k] = $signed(q_side.nums[k]);
                den_sel[ROLL+k] = q_side.d_roll;
                num_sel[YAW+k]  = $signed(q_side.nums[4+k]);
                den_sel[YAW+k]  = q_side.d_yaw;
                den_sel[PITCH+k]  = {{(DEN_W-ROOT_W){1'b0}}, q_root};
                long_sel[PITCH+k] = 1'b1;
            end
            num_sel[PITCH+BY_X] = -two_z;
            num_sel[PITCH+BY_Y] = two_w;
            num_sel[PITCH+BY_Z] = -two_x;
            num_sel[PITCH+BY_W] = two_y;
        end
    end

    for (genvar k = 0; k < N_ENT; k++) begin : g_div
        ejq_div u_div (
            .aclk       (aclk),
            .en         (adv),
            .num        (num_sel[k]),
            .long_shift (long_sel[k]),
            .den        (den_sel[k]),
            .result     (div_res[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < DIV_STAGES; s++) begin
                div_vld_reg[s] <= 1'b0;
            end
        end else if (adv) begin
            div_vld_reg[0] <= q_valid;
            for (int s = 1; s < DIV_STAGES; s++) begin
                div_vld_reg[s] <= div_vld_reg[s-1];
            end
        end
    end

    always_comb begin
        last_vld   = div_vld_reg[DIV_STAGES-1];
        load_out   = adv && last_vld && (!m_valid_reg || m_ready);
        load_skid  = adv && last_vld && m_valid_reg && !m_ready;
        drain_skid = !adv && m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (load_out || drain_skid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (load_skid) begin
                skid_valid_reg <= 1'b1;
            end else if (drain_skid) begin
                skid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < N_ENT; k++) begin
            if (load_out) begin
                out_data_reg[k] <= div_res[k];
            end else if (drain_skid) begin
                out_data_reg[k] <= skid_data_reg[k];
            end
            if (load_skid) begin
                skid_data_reg[k] <= div_res[k];
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_roll_by_x  = $signed(out_data_reg[ROLL+BY_X]);
    assign m_roll_by_y  = $signed(out_data_reg[ROLL+BY_Y]);
    assign m_roll_by_z  = $signed(out_data_reg[ROLL+BY_Z]);
    assign m_roll_by_w  = $signed(out_data_reg[ROLL+BY_W]);
    assign m_pitch_by_x = $signed(out_data_reg[PITCH+BY_X]);
    assign m_pitch_by_y = $signed(out_data_reg[PITCH+BY_Y]);
    assign m_pitch_by_z = $signed(out_data_reg[PITCH+BY_Z]);
    assign m_pitch_by_w = $signed(out_data_reg[PITCH+BY_W]);
    assign m_yaw_by_x   = $signed(out_data_reg[YAW+BY_X]);
    assign m_yaw_by_y   = $signed(out_data_reg[YAW+BY_Y]);
    assign m_yaw_by_z   = $signed(out_data_reg[YAW+BY_Z]);
    assign m_yaw_by_w   = $signed(out_data_reg[YAW+BY_W]);

endmodule

### hw/rtl/ejq_checker.sv
// Port-level checker for the Jacobian block and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ejq_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready
);

    // A result that is not taken stays offered.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    // Reset empties the output side.
    `ASSERT_NEXT_NORST(a_reset_empty, aclk, !aresetn, !m_valid)
    // The input side only closes when the output register holds an item.
    `ASSERT_IMPLY(a_ready_low_needs_out, aclk, aresetn, !s_ready, m_valid)
    // With the skid full, a taken result is followed at once by the skid item.
    `ASSERT_NEXT(a_skid_drain, aclk, aresetn, m_valid && m_ready && !s_ready, m_valid)

endmodule

bind euler_from_quaternion_jacobian ejq_checker u_ejq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready)
);
